FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic signed [DATA_W-1:0] t_data;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic  en;
        logic  deq;
        t_data val;
    } t_bcast;

endpackage
`default_nettype wire

FILE: rtl/core/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted largest first in a chain of cells.
// ----------------------------------------------------------------------------
// Each beat is an enqueue or a dequeue and yields one result beat. Every cell
// compares its entry with the incoming value in parallel and updates from
// itself, the new value or a neighbor in the same cycle, so one beat is taken
// per cycle unless the output stalls; the result is registered on acceptance,
// and a new beat is taken while that result waits as long as it leaves in the
// same cycle. Equal values leave in arrival order. A dequeue on an empty queue
// reports status 1 and an enqueue into a full queue is dropped with status 2.
// Entries are not cleared by reset; only the count and output valid are.
module sorted_priority_queue_unit #(
    parameter int unsigned CAPACITY = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_operation,
    input  wire spq_pkg::t_data          i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output spq_pkg::t_data               o_popped_value,
    output logic [spq_pkg::STATUS_W-1:0] o_status,
    output spq_pkg::t_data               o_head_value,
    output logic [spq_pkg::OCC_W-1:0]    o_occupancy,
    output logic                         o_is_full
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    t_status       w_status;
    t_bcast        w_bc;

    t_data w_val [CAPACITY];
    t_data w_nxt [CAPACITY];
    logic  w_ge  [CAPACITY];

    logic          r_out_valid;
    t_data         r_popped;
    t_status       r_status;
    t_data         r_head;
    logic [CW-1:0] r_occ;
    logic          r_full;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CAP);
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_bc.deq = i_operation;
        w_bc.val = i_value;
        w_bc.en  = 1'b0;
        n_count  = r_count;
        w_status = ST_OK;
        if (i_operation) begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                w_bc.en = w_accept;
                n_count = r_count - CW'(1);
            end
        end else begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_bc.en = w_accept;
                n_count = r_count + CW'(1);
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_bc       (w_bc),
            .i_vld      (CW'(g) < r_count),
            .i_prev_ge  ((g == 0) ? 1'b1 : w_ge[(g == 0) ? 0 : g - 1]),
            .i_prev_val (w_val[(g == 0) ? 0 : g - 1]),
            .i_next_val (w_val[(g == CAPACITY - 1) ? g : g + 1]),
            .o_val      (w_val[g]),
            .o_nxt      (w_nxt[g]),
            .o_ge       (w_ge[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= (i_operation && !w_empty) ? w_val[0] : '0;
            r_status <= w_status;
            r_head   <= (n_count == '0) ? '0 : (w_bc.en ? w_nxt[0] : w_val[0]);
            r_occ    <= n_count;
            r_full   <= (n_count == CAP);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_head_value   = r_head;
    assign o_occupancy    = OCC_W'(r_occ);
    assign o_is_full      = r_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("count exceeds capacity");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_operation && !w_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("enqueue did not grow count");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation && !w_empty) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("dequeue did not shrink count");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (r_occ == '0 && r_popped == '0))
        else $error("empty status with stored entries");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> r_full)
        else $error("full status without full flag");

endmodule
`default_nettype wire

FILE: rtl/core/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  wire logic          i_clk,
    input  wire spq_pkg::t_bcast i_bc,
    input  wire logic          i_vld,
    input  wire logic          i_prev_ge,
    input  wire spq_pkg::t_data i_prev_val,
    input  wire spq_pkg::t_data i_next_val,
    output spq_pkg::t_data     o_val,
    output spq_pkg::t_data     o_nxt,
    output logic               o_ge
);
    import spq_pkg::*;

    t_data r_val;
    t_data n_val;

    assign o_ge  = i_vld && (r_val >= i_bc.val);
    assign o_val = r_val;
    assign o_nxt = n_val;

    always_comb begin
        if (i_bc.deq) begin
            n_val = i_next_val;
        end else if (o_ge) begin
            n_val = r_val;
        end else if (i_prev_ge) begin
            n_val = i_bc.val;
        end else begin
            n_val = i_prev_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bc.en) begin
            r_val <= n_val;
        end
    end

endmodule
`default_nettype wire

FILE: dv/sorted_priority_queue_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_test
// Self-checking bench for the sorted priority queue. Enqueue and dequeue
// beats go in through a valid/ready port. A mirror of the sorted store
// predicts each result beat, and each result beat is compared field by field
// with the oldest prediction. Directed beats cover the value extremes, the
// empty and full cases and ties. Random beats then sweep the queue between
// empty and full, with random gaps and output stalls and then without them.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test;
    import spq_pkg::*;

    localparam int unsigned CAPACITY    = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic        OP_ENQUEUE  = 1'b0;
    localparam logic        OP_DEQUEUE  = 1'b1;

    typedef struct packed {
        t_data            popped;
        t_status          status;
        t_data            head;
        logic [OCC_W-1:0] occ;
        logic             full;
    } t_queue_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_operation;
    t_data               i_value;
    logic                o_out_valid;
    logic                i_out_ready;
    t_data               o_popped_value;
    logic [STATUS_W-1:0] o_status;
    t_data               o_head_value;
    logic [OCC_W-1:0]    o_occupancy;
    logic                o_is_full;

    t_data         mirror_store [CAPACITY];
    int unsigned   mirror_count;
    t_queue_result pending_results [$];
    int unsigned   error_count;
    int unsigned   cycle_count;
    bit            gaps_enabled;
    int unsigned   stall_left;

    sorted_priority_queue_unit #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_head_value   (o_head_value),
        .o_occupancy    (o_occupancy),
        .o_is_full      (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    function automatic t_queue_result predict_queue_step(input logic op, input t_data val);
        t_queue_result r;
        int unsigned   pos;
        r.popped = '0;
        r.status = ST_OK;
        if (op == OP_ENQUEUE) begin
            if (mirror_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < mirror_count && !(mirror_store[pos] < val)) pos++;
                for (int unsigned i = mirror_count; i > pos; i--) begin
                    mirror_store[i] = mirror_store[i-1];
                end
                mirror_store[pos] = val;
                mirror_count++;
            end
        end else begin
            if (mirror_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped = mirror_store[0];
                for (int unsigned i = 1; i < mirror_count; i++) begin
                    mirror_store[i-1] = mirror_store[i];
                end
                mirror_count--;
            end
        end
        r.head = (mirror_count > 0) ? mirror_store[0] : '0;
        r.occ  = mirror_count[OCC_W-1:0];
        r.full = (mirror_count == CAPACITY);
        return r;
    endfunction

    // hold the beat until accepted, then optionally leave a gap
    task automatic send_beat(input logic op, input t_data val);
        i_in_valid  = 1'b1;
        i_operation = op;
        i_value     = val;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pending_results.push_back(predict_queue_step(op, val));
        @(negedge i_clk);
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_data pick_value();
        case ($urandom_range(0, 5))
            0, 1:    return t_data'($urandom);
            2:       return t_data'(int'($urandom_range(0, 8)) - 4);
            3:       return t_data'($urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF :
                                    $urandom_range(0, 2) == 0 ? 32'h8000_0000 :
                                    $urandom_range(0, 1) == 0 ? 32'h0 : 32'hFFFF_FFFF);
            4:       return t_data'(32'h7FFF_FFFF - $urandom_range(0, 3));
            default: return t_data'(32'h8000_0000 + $urandom_range(0, 3));
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            i_out_ready = 1'b0;
            stall_left  = $urandom_range(1, 4) - 1;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_error("result beat with no expectation waiting");
            end else begin
                want = pending_results.pop_front();
                check_field("popped_value", o_popped_value, want.popped);
                check_field("status", 32'(o_status), 32'(want.status));
                check_field("head_value", o_head_value, want.head);
                check_field("occupancy", 32'(o_occupancy), 32'(want.occ));
                check_field("is_full", 32'(o_is_full), 32'(want.full));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_empty_dequeue();
        send_beat(OP_DEQUEUE, t_data'(32'h7FFF_FFFF));
        send_beat(OP_DEQUEUE, t_data'(32'h8000_0000));
    endtask

    task automatic test_fill_and_drain();
        send_beat(OP_ENQUEUE, t_data'(32'h8000_0000));
        send_beat(OP_ENQUEUE, t_data'(32'h7FFF_FFFF));
        send_beat(OP_ENQUEUE, t_data'(32'h0));
        send_beat(OP_ENQUEUE, t_data'(32'hFFFF_FFFF));
        send_beat(OP_ENQUEUE, t_data'(5));
        send_beat(OP_ENQUEUE, t_data'(5));
        send_beat(OP_ENQUEUE, t_data'(32'h8000_0000));
        send_beat(OP_ENQUEUE, t_data'(32'h7FFF_FFFF));
        send_beat(OP_ENQUEUE, t_data'(32'h7FFF_FFFF));
        send_beat(OP_ENQUEUE, t_data'(32'h5555_AAAA));
        repeat (CAPACITY + 1) send_beat(OP_DEQUEUE, t_data'(32'hAAAA_5555));
    endtask

    task automatic test_random_sweep(input int unsigned n_beats);
        int unsigned enq_pct;
        for (int unsigned k = 0; k < n_beats; k++) begin
            if (k % 30 == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
            end
            if (k == n_beats / 2) wait_for_drain();
            send_beat(($urandom_range(1, 100) <= enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                      pick_value());
        end
    endtask

    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        repeat (CAPACITY + 2) send_beat(OP_ENQUEUE, pick_value());
        test_random_sweep(100);
        repeat (CAPACITY + 2) send_beat(OP_DEQUEUE, pick_value());
    endtask

    initial begin
        error_count  = 0;
        cycle_count  = 0;
        mirror_count = 0;
        stall_left   = 0;
        gaps_enabled = 1'b1;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = OP_ENQUEUE;
        i_value      = '0;
        i_out_ready  = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_dequeue();
        test_fill_and_drain();
        test_random_sweep(480);
        test_back_to_back();

        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
